>>> src/alsp_pkg.sv
// shared types, constants and microcode encodings for the ambient light sensor poller
// no dependencies; imported by every module of the block
package alsp_pkg;

   // timer and field widths
   localparam int TIMER_WIDTH = 16;
   localparam int TIMER_CMP_W = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;
   localparam int PROD_W      = 58;
   localparam int OPND_W      = 29;

   // lux arithmetic constants
   localparam int RAW_SCALE    = 1275;
   localparam int RAW_BIAS     = 1280;
   localparam int DIV10K_SHIFT = 41;
   localparam logic [27:0] DIV10K_MAGIC =
      28'(((64'd1 << DIV10K_SHIFT) + 64'd9999) / 64'd10000);
   localparam int DIV100_SHIFT = 31;
   localparam logic [24:0] DIV100_MAGIC =
      25'(((64'd1 << DIV100_SHIFT) + 64'd99) / 64'd100);
   localparam logic [7:0] FAIL_LIMIT = 8'd5;
   localparam logic [7:0] FAIL_MAX   = 8'd255;

   // register reset values
   localparam logic [9:0]         CAL_RESET    = 10'd100;
   localparam logic [15:0]        THR_RESET    = 16'd10;
   localparam logic [15:0]        PERIOD_RESET = 16'd5;
   localparam logic signed [15:0] GAIN_RESET   = 16'sd1;
   localparam logic signed [15:0] OFFSET_RESET = 16'sd0;

   typedef logic [2:0] csr_index_type;
   localparam csr_index_type CSR_CAL_PERCENT = 3'd0;
   localparam csr_index_type CSR_THRESHOLD   = 3'd1;
   localparam csr_index_type CSR_PERIOD      = 3'd2;
   localparam csr_index_type CSR_GAIN        = 3'd3;
   localparam csr_index_type CSR_OFFSET      = 3'd4;

   // transaction kinds; the failure code uses the same numbering
   typedef enum logic [2:0] {
      KIND_NONE    = 3'd0,
      KIND_INIT    = 3'd1,
      KIND_ENABLE  = 3'd2,
      KIND_POINTER = 3'd3,
      KIND_READ    = 3'd4
   } kind_type;

   typedef enum logic [5:0] {
      PH_INIT    = 6'b000001,
      PH_ENABLE  = 6'b000010,
      PH_POINTER = 6'b000100,
      PH_READ    = 6'b001000,
      PH_CHECK   = 6'b010000,
      PH_WAIT    = 6'b100000
   } phase_type;

   // microcode encodings
   typedef logic [2:0] step_type;
   localparam step_type ST_FETCH   = 3'd0;
   localparam step_type ST_SCALE   = 3'd1;
   localparam step_type ST_DIV10K  = 3'd2;
   localparam step_type ST_PERCENT = 3'd3;
   localparam step_type ST_DIV100  = 3'd4;
   localparam step_type ST_GAIN    = 3'd5;
   localparam step_type ST_LUX     = 3'd6;
   localparam step_type ST_COMMIT  = 3'd7;

   typedef enum logic [1:0] {
      WAIT_NONE = 2'd0,
      WAIT_ITEM = 2'd1,
      WAIT_SLOT = 2'd2
   } wait_type;

   typedef enum logic [1:0] {
      JMP_NEXT    = 2'd0,
      JMP_ALWAYS  = 2'd1,
      JMP_NO_CALC = 2'd2
   } jump_type;

   typedef enum logic [2:0] {
      MUL_NONE      = 3'd0,
      MUL_RAW_SCALE = 3'd1,
      MUL_DIV10K    = 3'd2,
      MUL_PERCENT   = 3'd3,
      MUL_DIV100    = 3'd4,
      MUL_GAIN      = 3'd5
   } mul_op_type;

   typedef struct packed {
      wait_type   wait_on;
      jump_type   jump_cond;
      step_type   jump_target;
      mul_op_type mul_op;
      logic       latch_item;
      logic       lux_store;
      logic       commit;
   } ucode_word_type;

   // sequencer to datapath, enables already qualified by stalls
   typedef struct packed {
      mul_op_type mul_op;
      logic       latch_item;
      logic       lux_store;
      logic       commit;
   } dp_ctl_type;

   typedef struct packed {
      logic item_valid;
      logic slot_busy;
      logic calc;
   } seq_status_type;

   typedef struct packed {
      kind_type           kind;
      logic signed [31:0] lux;
      logic               report;
      kind_type           failure;
   } result_type;

endpackage

>>> src/alsp_ucode_rom.sv
// microprogram store: one control word per sequencer step
// depends on alsp_pkg
module alsp_ucode_rom (
   input  alsp_pkg::step_type       step,
   output alsp_pkg::ucode_word_type word
);
   import alsp_pkg::*;

   always_comb begin
      word = '{wait_on: WAIT_NONE, jump_cond: JMP_NEXT, jump_target: ST_FETCH,
               mul_op: MUL_NONE, latch_item: 1'b0, lux_store: 1'b0, commit: 1'b0};
      unique case (step)
         ST_FETCH: begin
            word.wait_on    = WAIT_ITEM;
            word.latch_item = 1'b1;
         end
         ST_SCALE: begin
            word.mul_op      = MUL_RAW_SCALE;
            word.jump_cond   = JMP_NO_CALC;
            word.jump_target = ST_COMMIT;
         end
         ST_DIV10K:  word.mul_op = MUL_DIV10K;
         ST_PERCENT: word.mul_op = MUL_PERCENT;
         ST_DIV100:  word.mul_op = MUL_DIV100;
         ST_GAIN:    word.mul_op = MUL_GAIN;
         ST_LUX:     word.lux_store = 1'b1;
         ST_COMMIT: begin
            word.wait_on     = WAIT_SLOT;
            word.commit      = 1'b1;
            word.jump_cond   = JMP_ALWAYS;
            word.jump_target = ST_FETCH;
         end
      endcase
   end

endmodule

>>> src/alsp_sequencer.sv
// step counter with wait and jump handling around the microprogram store
// depends on alsp_pkg and alsp_ucode_rom
module alsp_sequencer (
   input  logic                     clock,
   input  logic                     reset,
   input  alsp_pkg::seq_status_type status,
   output logic                     item_ready,
   output alsp_pkg::dp_ctl_type     ctl
);
   import alsp_pkg::*;

   step_type       step_ff, step_in;
   ucode_word_type word;
   logic           hold;
   logic           take_jump;

   alsp_ucode_rom u_rom (
      .step (step_ff),
      .word (word)
   );

   always_comb begin
      hold = ((word.wait_on == WAIT_ITEM) && !status.item_valid) ||
             ((word.wait_on == WAIT_SLOT) && status.slot_busy);
      unique case (word.jump_cond)
         JMP_ALWAYS:  take_jump = 1'b1;
         JMP_NO_CALC: take_jump = !status.calc;
         default:     take_jump = 1'b0;
      endcase
      priority if (hold)      step_in = step_ff;
      else if (take_jump)     step_in = word.jump_target;
      else                    step_in = step_ff + 3'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ST_FETCH;
      end else begin
         step_ff <= step_in;
      end
   end

   assign item_ready     = (word.wait_on == WAIT_ITEM);
   assign ctl.mul_op     = hold ? MUL_NONE : word.mul_op;
   assign ctl.latch_item = word.latch_item && !hold;
   assign ctl.lux_store  = word.lux_store && !hold;
   assign ctl.commit     = word.commit && !hold;

endmodule

>>> src/alsp_datapath.sv
// datapath: settings registers, item latch, shared multiplier, lux and poll state
// depends on alsp_pkg
module alsp_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  alsp_pkg::dp_ctl_type  ctl,
   input  logic                  csr_write_en,
   input  alsp_pkg::csr_index_type csr_index,
   input  logic [15:0]           csr_wdata,
   input  logic                  txn_ok,
   input  logic [7:0]            data_low,
   input  logic [7:0]            data_high,
   input  logic [15:0]           seconds_now,
   output logic                  calc,
   output alsp_pkg::result_type  result
);
   import alsp_pkg::*;

   // settings
   logic [9:0]         cal_ff;
   logic [15:0]        thr_ff;
   logic [15:0]        period_ff;
   logic signed [15:0] gain_ff;
   logic signed [15:0] offset_ff;

   // latched item
   logic                   ok_ff;
   logic [15:0]            raw_ff;
   logic [TIMER_WIDTH-1:0] now_ff;

   // multiplier
   logic signed [OPND_W-1:0] opnd_a, opnd_b;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [26:0]              biased;

   // poll state
   phase_type              phase_ff, phase_in;
   logic [7:0]             fail_ff, fail_in, fail_inc;
   logic [TIMER_WIDTH-1:0] wait_start_ff, wait_start_in, elapsed;
   logic signed [31:0]     lux_ff, lux_in;
   logic signed [31:0]     reported_ff, reported_in;
   kind_type               latched_ff, latched_in;
   kind_type               kind;
   logic                   report;
   logic signed [34:0]     lux_sum;
   logic signed [32:0]     lux_diff;
   logic [32:0]            lux_dist;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff    <= CAL_RESET;
         thr_ff    <= THR_RESET;
         period_ff <= PERIOD_RESET;
         gain_ff   <= GAIN_RESET;
         offset_ff <= OFFSET_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_CAL_PERCENT: cal_ff    <= csr_wdata[9:0];
            CSR_THRESHOLD:   thr_ff    <= csr_wdata;
            CSR_PERIOD:      period_ff <= csr_wdata;
            CSR_GAIN:        gain_ff   <= csr_wdata;
            CSR_OFFSET:      offset_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.latch_item) begin
         ok_ff  <= txn_ok;
         raw_ff <= {data_high, data_low};
         now_ff <= TIMER_WIDTH'(seconds_now);
      end
   end

   // scaled raw counts below the bias divide to zero
   assign biased = (prod_ff[26:0] < 27'(RAW_BIAS)) ? '0 : prod_ff[26:0] - 27'(RAW_BIAS);

   always_comb begin
      unique case (ctl.mul_op)
         MUL_RAW_SCALE: begin
            opnd_a = OPND_W'(raw_ff);
            opnd_b = OPND_W'(RAW_SCALE);
         end
         MUL_DIV10K: begin
            opnd_a = OPND_W'(biased);
            opnd_b = OPND_W'(DIV10K_MAGIC);
         end
         MUL_PERCENT: begin
            opnd_a = OPND_W'(prod_ff[PROD_W-1:DIV10K_SHIFT]);
            opnd_b = OPND_W'(cal_ff);
         end
         MUL_DIV100: begin
            opnd_a = OPND_W'(prod_ff[23:0]);
            opnd_b = OPND_W'(DIV100_MAGIC);
         end
         MUL_GAIN: begin
            opnd_a = OPND_W'(gain_ff);
            opnd_b = OPND_W'(prod_ff[47:DIV100_SHIFT]);
         end
         default: begin
            opnd_a = '0;
            opnd_b = '0;
         end
      endcase
      prod_in = opnd_a * opnd_b;
   end

   always_ff @(posedge clock) begin
      if (ctl.mul_op != MUL_NONE) begin
         prod_ff <= prod_in;
      end
   end

   // offset add and saturation to 32 bits
   always_comb begin
      lux_sum = $signed(prod_ff[34:0]) + 35'(offset_ff);
      if (lux_sum[34:31] == 4'b0000 || lux_sum[34:31] == 4'b1111) begin
         lux_in = lux_sum[31:0];
      end else if (lux_sum[34]) begin
         lux_in = {1'b1, 31'd0};
      end else begin
         lux_in = {1'b0, {31{1'b1}}};
      end
   end

   assign calc = (phase_ff == PH_READ) && ok_ff;

   // step commit
   always_comb begin
      phase_in      = phase_ff;
      fail_in       = fail_ff;
      wait_start_in = wait_start_ff;
      reported_in   = reported_ff;
      latched_in    = latched_ff;
      kind          = KIND_NONE;
      report        = 1'b0;
      fail_inc      = (fail_ff == FAIL_MAX) ? FAIL_MAX : fail_ff + 8'd1;
      lux_diff      = 33'(lux_ff) - 33'(reported_ff);
      lux_dist      = lux_diff[32] ? 33'(-lux_diff) : 33'(lux_diff);
      elapsed       = now_ff - wait_start_ff;
      unique case (phase_ff)
         PH_INIT, PH_ENABLE, PH_POINTER, PH_READ: begin
            unique case (phase_ff)
               PH_INIT:    kind = KIND_INIT;
               PH_ENABLE:  kind = KIND_ENABLE;
               PH_POINTER: kind = KIND_POINTER;
               default:    kind = KIND_READ;
            endcase
            if (ok_ff) begin
               fail_in = '0;
               unique case (phase_ff)
                  PH_INIT:    phase_in = PH_ENABLE;
                  PH_ENABLE:  phase_in = PH_POINTER;
                  PH_POINTER: phase_in = PH_READ;
                  default:    phase_in = PH_CHECK;
               endcase
            end else begin
               fail_in = fail_inc;
               if (fail_inc > FAIL_LIMIT) begin
                  latched_in = kind;
               end
            end
         end
         PH_CHECK: begin
            if (lux_dist >= 33'(thr_ff)) begin
               reported_in = lux_ff;
               report      = 1'b1;
            end
            wait_start_in = now_ff;
            phase_in      = PH_WAIT;
         end
         PH_WAIT: begin
            if (TIMER_CMP_W'(elapsed) >= TIMER_CMP_W'(period_ff)) begin
               phase_in = PH_POINTER;
               fail_in  = '0;
            end
         end
         default: phase_in = PH_INIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_INIT;
         fail_ff       <= '0;
         wait_start_ff <= '0;
         lux_ff        <= '0;
         reported_ff   <= '0;
         latched_ff    <= KIND_NONE;
      end else begin
         if (ctl.lux_store) begin
            lux_ff <= lux_in;
         end
         if (ctl.commit) begin
            phase_ff      <= phase_in;
            fail_ff       <= fail_in;
            wait_start_ff <= wait_start_in;
            reported_ff   <= reported_in;
            latched_ff    <= latched_in;
         end
      end
   end

   assign result.kind    = kind;
   assign result.lux     = lux_ff;
   assign result.report  = report;
   assign result.failure = latched_in;

endmodule

>>> src/ambient_light_sensor_poller.sv
// top level of the ambient light sensor poller: sequencer, datapath and result register
// depends on alsp_pkg, alsp_sequencer, alsp_datapath
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_ready   txn_ok, data_low, data_high, seconds_now
//   rsp      out        rsp_valid/rsp_ready   txn_kind, lux_value, report, failure_code
//   csr      in         csr_write_en          csr_index, csr_wdata
//
// most poll steps pass fetch, scale and commit; a successful read also passes div10k,
//   percent, div100, gain and lux, reusing one multiplier for five products in a row
// one result per item, held in an output register so the next item can be
//   taken while the previous result waits
// a stalled result holds the commit step, and with it the next item's result
// reset is synchronous; registers, poll state and step counter return to power-on
module ambient_light_sensor_poller (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_txn_ok,
   input  logic [7:0]         req_data_low,
   input  logic [7:0]         req_data_high,
   input  logic [15:0]        req_seconds_now,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_txn_kind,
   output logic signed [31:0] rsp_lux_value,
   output logic               rsp_report,
   output logic [2:0]         rsp_failure_code,
   input  logic               csr_write_en,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_wdata
);
   import alsp_pkg::*;

   seq_status_type     status;
   dp_ctl_type         ctl;
   result_type         result;
   logic               calc;

   // result register
   logic               rsp_valid_ff;
   logic [2:0]         rsp_kind_ff;
   logic signed [31:0] rsp_lux_ff;
   logic               rsp_report_ff;
   logic [2:0]         rsp_fail_ff;

   // the commit step waits only while a result is stuck in the output register
   assign status.item_valid = req_valid;
   assign status.slot_busy  = rsp_valid_ff && !rsp_ready;
   assign status.calc       = calc;

   alsp_sequencer u_seq (
      .clock      (clock),
      .reset      (reset),
      .status     (status),
      .item_ready (req_ready),
      .ctl        (ctl)
   );

   alsp_datapath u_dp (
      .clock        (clock),
      .reset        (reset),
      .ctl          (ctl),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .txn_ok       (req_txn_ok),
      .data_low     (req_data_low),
      .data_high    (req_data_high),
      .seconds_now  (req_seconds_now),
      .calc         (calc),
      .result       (result)
   );

   // valid: set by a commit, cleared once the item is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // payload of the result register
   always_ff @(posedge clock) begin
      if (ctl.commit) begin
         rsp_kind_ff   <= result.kind;
         rsp_lux_ff    <= result.lux;
         rsp_report_ff <= result.report;
         rsp_fail_ff   <= result.failure;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_txn_kind     = rsp_kind_ff;
   assign rsp_lux_value    = rsp_lux_ff;
   assign rsp_report       = rsp_report_ff;
   assign rsp_failure_code = rsp_fail_ff;

endmodule

>>> src/alsp_checker.sv
// port-level checks for the ambient light sensor poller, bound to the top level
// depends on alsp_pkg and ambient_light_sensor_poller
module alsp_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [2:0]         rsp_txn_kind,
   input logic signed [31:0] rsp_lux_value,
   input logic               rsp_report,
   input logic [2:0]         rsp_failure_code
);
   import alsp_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_txn_kind) &&
         $stable(rsp_lux_value) && $stable(rsp_report) && $stable(rsp_failure_code))
      else $error("result changed while stalled");

   // a report only comes from a check step, which issues no transaction
   a_report_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_report |-> rsp_txn_kind == KIND_NONE)
      else $error("report with a bus transaction");

   // one item at a time, and no result in the cycle after an accept
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready && !$rose(rsp_valid))
      else $error("item overlap after accept");

   // a latched failure is sticky
   a_fail_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_failure_code != KIND_NONE |=>
         !rsp_valid || rsp_failure_code != KIND_NONE)
      else $error("failure code cleared");

endmodule

bind ambient_light_sensor_poller alsp_checker u_checker (.*);

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// self-checking bench for ambient_light_sensor_poller: directed table, then random poll steps
// depends on alsp_pkg and the poller rtl; an internal predictor computes every expected result but for typed rows
module tb;
   import alsp_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int NUM_SETTINGS  = 6;
   localparam int RANDOM_ITEMS  = 155;   // random items per register setting
   localparam int DIRECTED_ROWS = 25;
   localparam int LONG_HOLD     = 200;   // cycles the receiver holds off once

   // one row of the directed table; the typed result is only used when typed is set
   typedef struct packed {
      logic       ok;
      logic [7:0] data_lo;
      logic [7:0] data_hi;
      logic [15:0] secs;
      logic       typed;
      result_type want;
   } poll_row_type;

   // one full register setting, written field by field
   typedef struct packed {
      logic [15:0] cal;
      logic [15:0] thr;
      logic [15:0] period;
      logic [15:0] gain;
      logic [15:0] offset;
   } csr_set_type;

   // dut ports, all inputs driven from time zero
   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_txn_ok = 1'b0;
   logic [7:0]         req_data_low = 8'h00;
   logic [7:0]         req_data_high = 8'h00;
   logic [15:0]        req_seconds_now = 16'h0000;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [2:0]         rsp_txn_kind;
   logic signed [31:0] rsp_lux_value;
   logic               rsp_report;
   logic [2:0]         rsp_failure_code;
   logic               csr_write_en = 1'b0;
   csr_index_type      csr_index = CSR_CAL_PERCENT;
   logic [15:0]        csr_wdata = 16'h0000;

   // predictor copy of the registers
   logic [9:0]         cal_pct;
   logic [15:0]        thr;
   logic [15:0]        period;
   logic signed [15:0] gain;
   logic signed [15:0] offset;

   // predictor copy of the poll state
   phase_type          ph;
   logic [7:0]         fails;
   logic [15:0]        wait_start;
   logic signed [31:0] cur_lux;
   logic signed [31:0] sent_lux;
   kind_type           latched;

   result_type         pending_results [$];
   result_type         want;
   poll_row_type       directed_steps [DIRECTED_ROWS];
   csr_set_type        fixed_sets [4];
   int                 mismatches = 0;
   int                 results_seen = 0;
   int                 cycle_count = 0;
   bit                 quiet = 1'b0;     // no idling on either side
   bit                 held_off = 1'b0;

   ambient_light_sensor_poller uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_txn_ok       (req_txn_ok),
      .req_data_low     (req_data_low),
      .req_data_high    (req_data_high),
      .req_seconds_now  (req_seconds_now),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_txn_kind     (rsp_txn_kind),
      .rsp_lux_value    (rsp_lux_value),
      .rsp_report       (rsp_report),
      .rsp_failure_code (rsp_failure_code),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #4 clock = ~clock;

   // one poll step of the predictor: advances its state, returns the result it expects
   function automatic result_type predict_poll(logic ok, logic [7:0] lo, logic [7:0] hi,
                                               logic [15:0] now);
      result_type r;
      kind_type   kind;
      phase_type  nxt;
      logic [15:0] raw;
      logic [15:0] elapsed;
      longint     x;
      longint     diff;
      kind = KIND_NONE;
      nxt = ph;
      r.report = 1'b0;
      raw = {hi, lo};
      case (ph)
         PH_INIT: begin
            kind = KIND_INIT;
            nxt = PH_ENABLE;
         end
         PH_ENABLE: begin
            kind = KIND_ENABLE;
            nxt = PH_POINTER;
         end
         PH_POINTER: begin
            kind = KIND_POINTER;
            nxt = PH_READ;
         end
         PH_READ: begin
            kind = KIND_READ;
            nxt = PH_CHECK;
         end
         PH_CHECK: begin
            // distance taken in 64 bits so it cannot overflow
            diff = longint'(cur_lux) - longint'(sent_lux);
            if (diff < 0) diff = -diff;
            if (diff >= longint'(thr)) begin
               sent_lux = cur_lux;
               r.report = 1'b1;
            end
            wait_start = now;
            ph = PH_WAIT;
         end
         PH_WAIT: begin
            elapsed = now - wait_start;   // wraps with the 16 bit timer
            if (elapsed >= period) begin
               ph = PH_POINTER;
               fails = 8'd0;
            end
         end
         default: ph = PH_INIT;
      endcase
      if (kind != KIND_NONE) begin
         if (ok) begin
            if (ph == PH_READ) begin
               // divisions truncate toward zero, then gain and offset, then clamp
               x = longint'(raw) * 1275 - 1280;
               x = x / 10000;
               x = x * longint'(cal_pct) / 100;
               x = longint'(gain) * x + longint'(offset);
               if (x > 64'sd2147483647) x = 64'sd2147483647;
               else if (x < -64'sd2147483648) x = -64'sd2147483648;
               cur_lux = x[31:0];
            end
            ph = nxt;
            fails = 8'd0;
         end else begin
            if (fails != 8'd255) fails = fails + 8'd1;
            if (fails > 8'd5) latched = kind;
         end
      end
      r.kind = kind;
      r.lux = cur_lux;
      r.failure = latched;
      return r;
   endfunction

   // register write, called at a falling edge; the caller lowers the enable afterwards
   task automatic set_register(csr_index_type idx, logic [15:0] value);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      case (idx)
         CSR_CAL_PERCENT: cal_pct = value[9:0];
         CSR_THRESHOLD:   thr = value;
         CSR_PERIOD:      period = value;
         CSR_GAIN:        gain = value;
         CSR_OFFSET:      offset = value;
         default: ;
      endcase
   endtask

   // offer one poll step, wait for it to be taken, queue what it should produce
   task automatic offer_step(logic ok, logic [7:0] lo, logic [7:0] hi, logic [15:0] now,
                             logic typed, result_type typed_result);
      result_type predicted;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_txn_ok <= ok;
      req_data_low <= lo;
      req_data_high <= hi;
      req_seconds_now <= now;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      predicted = predict_poll(ok, lo, hi, now);
      // typed rows check the block against hand-read values instead
      pending_results.push_back(typed ? typed_result : predicted);
      @(negedge clock);
   endtask

   // stimulus: reset, directed table, then random steps under several settings
   initial begin
      logic        ok;
      logic [7:0]  lo;
      logic [7:0]  hi;
      logic [15:0] now;
      int          fail_run;
      csr_set_type cfg;
      fail_run = 0;

      cal_pct = CAL_RESET;
      thr = THR_RESET;
      period = PERIOD_RESET;
      gain = GAIN_RESET;
      offset = OFFSET_RESET;
      ph = PH_INIT;
      fails = 8'd0;
      wait_start = 16'd0;
      cur_lux = 32'sd0;
      sent_lux = 32'sd0;
      latched = KIND_NONE;

      // extremes: full scale gain and offset both ways, zero and full thresholds
      fixed_sets = '{
         '{16'd1000, 16'd0,     16'd0,     16'h7FFF, 16'h7FFF},
         '{16'd1000, 16'hFFFF,  16'hFFFF,  16'h8000, 16'h8000},
         '{16'd0,    16'd1,     16'd1,     16'd0,    16'd12345},
         '{16'd250,  16'd500,   16'd3,     16'hFFFD, 16'd7}
      };

      directed_steps = '{
         // init fails, first one shows nothing latched
         '{1'b0, 8'h00, 8'h00, 16'h0000, 1'b1, '{KIND_INIT, 32'sd0, 1'b0, KIND_NONE}},
         '{1'b0, 8'hFF, 8'hFF, 16'hFFFF, 1'b0, '0},
         '{1'b0, 8'h00, 8'h00, 16'h0000, 1'b0, '0},
         '{1'b0, 8'hA5, 8'h5A, 16'h1234, 1'b0, '0},
         '{1'b0, 8'h00, 8'h00, 16'h0000, 1'b0, '0},
         // sixth failure in a row latches the init code
         '{1'b0, 8'h00, 8'h00, 16'h0000, 1'b1, '{KIND_INIT, 32'sd0, 1'b0, KIND_INIT}},
         '{1'b1, 8'h00, 8'h00, 16'h0000, 1'b0, '0},
         // enable fails until its code takes over the latch
         '{1'b0, 8'h00, 8'h00, 16'h0000, 1'b0, '0},
         '{1'b0, 8'hFF, 8'h00, 16'h00FF, 1'b0, '0},
         '{1'b0, 8'h00, 8'hFF, 16'hFF00, 1'b0, '0},
         '{1'b0, 8'h00, 8'h00, 16'h0000, 1'b0, '0},
         '{1'b0, 8'h00, 8'h00, 16'h0000, 1'b0, '0},
         '{1'b0, 8'h00, 8'h00, 16'h0000, 1'b1, '{KIND_ENABLE, 32'sd0, 1'b0, KIND_ENABLE}},
         '{1'b1, 8'h00, 8'h00, 16'h0000, 1'b0, '0},
         '{1'b1, 8'h00, 8'h00, 16'h0000, 1'b0, '0},
         // full scale raw count
         '{1'b1, 8'hFF, 8'hFF, 16'h0000, 1'b1, '{KIND_READ, 32'sd8355, 1'b0, KIND_ENABLE}},
         // check ignores txn_ok, change reaches threshold
         '{1'b0, 8'h00, 8'h00, 16'd100,  1'b1, '{KIND_NONE, 32'sd8355, 1'b1, KIND_ENABLE}},
         '{1'b0, 8'h00, 8'h00, 16'd104,  1'b0, '0},
         '{1'b0, 8'h00, 8'h00, 16'd105,  1'b0, '0},
         '{1'b1, 8'h00, 8'h00, 16'h0000, 1'b0, '0},
         // zero raw count, bias truncates to zero
         '{1'b1, 8'h00, 8'h00, 16'h0000, 1'b1, '{KIND_READ, 32'sd0, 1'b0, KIND_ENABLE}},
         // check just before the timer wraps, data ignored
         '{1'b1, 8'hFF, 8'hFF, 16'hFFFE, 1'b1, '{KIND_NONE, 32'sd0, 1'b1, KIND_ENABLE}},
         '{1'b0, 8'h00, 8'h00, 16'h0003, 1'b0, '0},
         '{1'b1, 8'h00, 8'h00, 16'h0000, 1'b0, '0},
         // raw count of one still gives zero
         '{1'b1, 8'h01, 8'h00, 16'h0000, 1'b1, '{KIND_READ, 32'sd0, 1'b0, KIND_ENABLE}}
      };

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < DIRECTED_ROWS; i++)
         offer_step(directed_steps[i].ok, directed_steps[i].data_lo, directed_steps[i].data_hi,
                    directed_steps[i].secs, directed_steps[i].typed, directed_steps[i].want);

      for (int s = 0; s < NUM_SETTINGS; s++) begin
         if (s > 0) begin
            // registers only change with the block drained and settled
            req_valid <= 1'b0;
            while (pending_results.size() != 0) @(negedge clock);
            repeat (10) @(negedge clock);
            if (s <= 4) begin
               cfg = fixed_sets[s - 1];
            end else begin
               cfg.cal = 16'($urandom_range(0, 1000));
               cfg.thr = 16'($urandom_range(0, 2000));
               cfg.period = 16'($urandom_range(0, 8));
               cfg.gain = 16'($urandom_range(0, 65535));
               cfg.offset = 16'($urandom_range(0, 65535));
            end
            set_register(CSR_CAL_PERCENT, cfg.cal);
            set_register(CSR_THRESHOLD, cfg.thr);
            set_register(CSR_PERIOD, cfg.period);
            set_register(CSR_GAIN, cfg.gain);
            set_register(CSR_OFFSET, cfg.offset);
            csr_write_en <= 1'b0;
         end
         quiet = (s == NUM_SETTINGS - 1);

         for (int i = 0; i < RANDOM_ITEMS; i++) begin
            // mostly successful transactions, with the odd burst of failures
            if (fail_run > 0) begin
               ok = 1'b0;
               fail_run--;
            end else if ($urandom_range(0, 29) == 0) begin
               ok = 1'b0;
               fail_run = $urandom_range(0, 7);
            end else begin
               ok = ($urandom_range(0, 19) != 0);
            end
            case ($urandom_range(0, 7))
               0: begin
                  lo = 8'h00;
                  hi = 8'h00;
               end
               1: begin
                  lo = 8'hFF;
                  hi = 8'hFF;
               end
               default: begin
                  lo = 8'($urandom_range(0, 255));
                  hi = 8'($urandom_range(0, 255));
               end
            endcase
            // while waiting, aim near the end of the period half of the time
            if (ph == PH_WAIT && $urandom_range(0, 1) == 1)
               now = wait_start + period + 16'($urandom_range(0, 4)) - 16'd2;
            else
               now = 16'($urandom_range(0, 65535));
            offer_step(ok, lo, hi, now, 1'b0, '0);
         end
      end

      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0 && pending_results.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // result side ready: random stalls, one long hold-off so the input backs up
   initial begin
      forever begin
         @(negedge clock);
         if (!held_off && results_seen >= 300) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            held_off = 1'b1;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   // compare each taken result with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            $error("result item with nothing pending");
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_txn_kind !== want.kind) begin
               $error("txn_kind: expected %0d, got %0d", want.kind, rsp_txn_kind);
               mismatches++;
            end
            if (rsp_lux_value !== want.lux) begin
               $error("lux_value: expected %0d, got %0d", want.lux, rsp_lux_value);
               mismatches++;
            end
            if (rsp_report !== want.report) begin
               $error("report: expected %0d, got %0d", want.report, rsp_report);
               mismatches++;
            end
            if (rsp_failure_code !== want.failure) begin
               $error("failure_code: expected %0d, got %0d", want.failure, rsp_failure_code);
               mismatches++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

endmodule

>>> filelist.f
src/alsp_pkg.sv
src/alsp_ucode_rom.sv
src/alsp_sequencer.sv
src/alsp_datapath.sv
src/ambient_light_sensor_poller.sv
src/alsp_checker.sv
tb/sv/tb.sv
